[design/leq_pkg.sv]
// ----------------------------------------------------------------------------
// leq_pkg: shared types and constants of the linked event queue
// Pool geometry, pointer and word formats, status codes and the reset
// value of the link store.
// ----------------------------------------------------------------------------
package leq_pkg;

   // Pool geometry.
   localparam int POOL_DEPTH = 16;
   localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Operation codes.
   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // A pool pointer: an index with a valid bit, where a clear bit is null.
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
   } ptr_type;

   // Input word.
   typedef struct packed {
      logic               mode;
      logic signed [31:0] event_value;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] event_out;
   } rsp_type;

   // Sequencer states.
   typedef enum logic {
      FSM_IDLE,
      FSM_BUSY
   } fsm_type;

   // Link held by an entry that has not been written since reset.
   function automatic ptr_type reset_link(input logic [IDX_W-1:0] idx);
      ptr_type p;
      p.vld = (idx != LAST_IDX);
      p.idx = IDX_W'(idx + 1'b1);
      return p;
   endfunction

endpackage

[design/linked_event_queue_with_free_list.sv]
// ----------------------------------------------------------------------------
// linked_event_queue_with_free_list: FIFO of event identifiers in a linked pool
// A word is accepted in idle, which registers the link and data store reads;
// once the result side is free, the busy state updates pointers and result.
// A dequeue writes its link then, an enqueue at accept. No new word is taken
// until the last completes, as the next free or front pointer waits for the
// link store read. Reset is synchronous and takes effect at once: per-entry
// valid bits make untouched links read as the in-order free chain.
// ----------------------------------------------------------------------------
module linked_event_queue_with_free_list
   import leq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Storage.
   logic [31:0]     data_mem [POOL_DEPTH];
   ptr_type         link_mem [POOL_DEPTH];
   logic [POOL_DEPTH-1:0] link_vld_ff, link_vld_in;

   // Control and pointer registers.
   fsm_type     state_ff, state_in;
   ptr_type     free_head_ff, free_head_in;
   ptr_type     front_ff, front_in;
   ptr_type     back_ff, back_in;
   logic        mode_ff, mode_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // Registered read port state.
   ptr_type          link_rd_ff;
   logic             link_rd_vld_ff;
   logic [IDX_W-1:0] link_rd_addr_ff;
   logic [31:0]      data_rd_ff;

   logic             accept;
   logic             complete;
   logic             enq_ok;
   logic             deq_ok;
   logic [IDX_W-1:0] rd_addr;
   logic             link_we;
   logic [IDX_W-1:0] link_waddr;
   ptr_type          link_wdata;
   ptr_type          link_rdata;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == FSM_IDLE);
   assign complete  = (state_ff == FSM_BUSY) && (!rsp_valid_ff || rsp_ready);
   assign enq_ok    = (req_data.mode == MODE_ENQ) && free_head_ff.vld;
   assign deq_ok    = (req_data.mode == MODE_DEQ) && front_ff.vld;

   // An enqueue reads the free head's link, a dequeue the front's.
   assign rd_addr = (req_data.mode == MODE_ENQ) ? free_head_ff.idx : front_ff.idx;

   // A link never written since reset reads as the in-order free chain.
   assign link_rdata = link_rd_vld_ff ? link_rd_ff : reset_link(link_rd_addr_ff);

   // Link writes: an enqueue chains the new entry after the back at accept;
   // a dequeue pushes the old front onto the free list at completion.
   always_comb begin
      link_we    = 1'b0;
      link_waddr = back_ff.idx;
      link_wdata = free_head_ff;
      if (accept && enq_ok && back_ff.vld) begin
         link_we    = 1'b1;
         link_waddr = back_ff.idx;
         link_wdata = free_head_ff;
      end else if (complete && (mode_ff == MODE_DEQ) && (status_ff == ST_OK)) begin
         link_we    = 1'b1;
         link_waddr = front_ff.idx;
         link_wdata = free_head_ff;
      end
   end

   // Link store with registered read.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (accept) begin
         link_rd_ff      <= link_mem[rd_addr];
         link_rd_vld_ff  <= link_vld_ff[rd_addr];
         link_rd_addr_ff <= rd_addr;
      end
   end

   // Data store with registered read.
   always_ff @(posedge clock) begin
      if (accept && enq_ok) begin
         data_mem[free_head_ff.idx] <= req_data.event_value;
      end
      if (accept) begin
         data_rd_ff <= data_mem[front_ff.idx];
      end
   end

   // Per-entry link valid bits.
   always_comb begin
      link_vld_in = link_vld_ff;
      if (link_we) begin
         link_vld_in[link_waddr] = 1'b1;
      end
   end

   // Next state, pointer updates and result.
   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      mode_in      = mode_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               mode_in  = req_data.mode;
               state_in = FSM_BUSY;
               if (req_data.mode == MODE_ENQ) begin
                  status_in = enq_ok ? ST_OK : ST_FULL;
               end else begin
                  status_in = deq_ok ? ST_OK : ST_EMPTY;
               end
            end
         end
         FSM_BUSY: begin
            if (complete) begin
               state_in              = FSM_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = status_ff;
               rsp_data_in.event_out = '0;
               if (status_ff == ST_OK) begin
                  if (mode_ff == MODE_ENQ) begin
                     free_head_in = link_rdata;
                     back_in      = free_head_ff;
                     if (!back_ff.vld) begin
                        front_in = free_head_ff;
                     end
                  end else begin
                     rsp_data_in.event_out = data_rd_ff;
                     free_head_in          = front_ff;
                     // The back entry's link may be stale, so its end is
                     // found by comparing with the back pointer.
                     if (front_ff.idx == back_ff.idx) begin
                        front_in = '0;
                        back_in  = '0;
                     end else begin
                        front_in = link_rdata;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= FSM_IDLE;
         free_head_ff.vld <= 1'b1;
         free_head_ff.idx <= '0;
         front_ff         <= '0;
         back_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         link_vld_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
         link_vld_ff  <= link_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted word keeps the input closed for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input accepted twice in a row");

   // The front and back pointers are null together.
   a_front_back_null: assert property (@(posedge clock) disable iff (reset)
      front_ff.vld == back_ff.vld)
      else $error("queue front and back disagree on empty");

   // A new result only appears out of the busy state.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_BUSY))
      else $error("result raised outside busy state");

   // A failed status never carries an identifier.
   a_fail_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_OK) |-> rsp_data_ff.event_out == '0)
      else $error("failed result carries an identifier");

endmodule

[verif/tb_linked_event_queue_with_free_list.sv]
// ----------------------------------------------------------------------------
// tb_linked_event_queue_with_free_list: self-checking bench of the event queue
// Drives enqueue and dequeue words with random gaps, stalls the result side
// at random, and checks each result word against a pool-level model of the
// free list and the queue chain kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_linked_event_queue_with_free_list
   import leq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 700;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 10;

   // Scoreboard: mirrors the pool and holds the expected result words.
   class leq_scoreboard;
      logic [31:0] slot_value [POOL_DEPTH];
      ptr_type     slot_next  [POOL_DEPTH];
      ptr_type     free_top;
      ptr_type     oldest;
      ptr_type     newest;
      rsp_type     expected_q [$];
      int          mismatches;
      int          results_seen;

      function new();
         mismatches   = 0;
         results_seen = 0;
         free_top     = to_ptr(0);
         oldest       = '0;
         newest       = '0;
         // Out of reset every entry sits on the free chain in index order.
         for (int i = 0; i < POOL_DEPTH; i++) begin
            slot_value[i] = '0;
            slot_next[i]  = (i + 1 < POOL_DEPTH) ? to_ptr(i + 1) : ptr_type'('0);
         end
      endfunction

      function ptr_type to_ptr(input int i);
         ptr_type p;
         p.vld = 1'b1;
         p.idx = IDX_W'(i);
         return p;
      endfunction

      // Works out the result of one accepted word and updates the pool.
      function void note_word(input req_type w);
         rsp_type            r;
         logic [IDX_W-1:0]   e;
         r.status    = ST_OK;
         r.event_out = '0;
         if (w.mode == MODE_ENQ) begin
            if (!free_top.vld) begin
               r.status = ST_FULL;
            end else begin
               e             = free_top.idx;
               free_top      = slot_next[e];
               slot_value[e] = w.event_value;
               slot_next[e]  = '0;
               if (newest.vld) begin
                  slot_next[newest.idx] = to_ptr(e);
               end else begin
                  oldest = to_ptr(e);
               end
               newest = to_ptr(e);
            end
         end else begin
            if (!oldest.vld) begin
               r.status = ST_EMPTY;
            end else begin
               e           = oldest.idx;
               r.event_out = slot_value[e];
               oldest      = slot_next[e];
               // Taking the last entry leaves the queue with no back entry either.
               if (!oldest.vld) begin
                  newest = '0;
               end
               slot_next[e] = free_top;
               free_top     = to_ptr(e);
            end
         end
         expected_q.push_back(r);
      endfunction

      // Compares one accepted result word with the oldest expectation.
      function void check_word(input rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word status=%0d event_out=%h",
                     $time, got.status, got.event_out);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatches++;
         end
         if (got.event_out !== want.event_out) begin
            $display("%0t: event_out mismatch, expected %h, actual %h",
                     $time, want.event_out, got.event_out);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   leq_scoreboard sb = new();
   int            words_sent  = 0;
   int            cycle_count = 0;
   bit            quiet       = 1'b0;

   linked_event_queue_with_free_list u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back to back, sometimes a short gap, rarely a long pause; none when quiet.
   function automatic int pick_gap();
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 30);
   endfunction

   // Result side: random stalls between stretches of ready.
   initial begin
      int stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Watches both handshakes; an input word is noted before a result is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_word(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_word(rsp_data);
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_linked_event_queue_with_free_list: errors");
         $finish;
      end
   end

   // Offers one word after a random gap and returns at the edge that takes it.
   // Valid stays high afterwards so that a following word can go back to back.
   task automatic send_word(input logic mode, input logic [31:0] value);
      req_type w;
      int      gap;
      w.mode        = mode;
      w.event_value = value;
      gap           = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Holds the sender off until every result so far has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.results_seen < words_sent) @(posedge clock);
   endtask

   task automatic send_burst(input logic mode, input int count);
      for (int i = 0; i < count; i++) begin
         send_word(mode, $urandom());
      end
   endtask

   initial begin
      int random_left;
      int kind;
      int len;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty dequeue, extreme identifiers, drain to empty again.
      send_word(MODE_DEQ, 32'h0);
      send_word(MODE_ENQ, 32'h8000_0000);
      send_word(MODE_ENQ, 32'h7fff_ffff);
      send_word(MODE_ENQ, 32'h0000_0000);
      send_word(MODE_ENQ, 32'hffff_ffff);
      send_word(MODE_ENQ, 32'haaaa_aaaa);
      send_word(MODE_ENQ, 32'h5555_5555);
      for (int i = 0; i < 6; i++) begin
         send_word(MODE_DEQ, 32'hffff_ffff);
      end
      send_word(MODE_DEQ, 32'h1234_5678);
      wait_drained();

      // Fill past capacity so the full rejection shows up, then drain past empty.
      random_left = RANDOM_WORDS - 2 * (POOL_DEPTH + 2);
      send_burst(MODE_ENQ, POOL_DEPTH + 2);
      send_burst(MODE_DEQ, POOL_DEPTH + 2);

      // Random sequences: runs of enqueues, runs of dequeues and loose mixes.
      while (random_left > 0) begin
         if ($urandom_range(0, 4) == 0) begin
            quiet = ~quiet;
         end
         if ($urandom_range(0, 19) == 0) begin
            wait_drained();
         end
         kind = $urandom_range(0, 99);
         len  = $urandom_range(1, 20);
         if (len > random_left) begin
            len = random_left;
         end
         if (kind < 40) begin
            send_burst(MODE_ENQ, len);
         end else if (kind < 75) begin
            send_burst(MODE_DEQ, len);
         end else begin
            for (int i = 0; i < len; i++) begin
               send_word(logic'($urandom_range(0, 1)), $urandom());
            end
         end
         random_left -= len;
      end

      // Let the last results come back, then allow for stray words.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("tb_linked_event_queue_with_free_list: clean");
      end else begin
         $display("tb_linked_event_queue_with_free_list: errors");
      end
      $finish;
   end

endmodule
